FILE: sv/rss_pkg.sv
`timescale 1ns / 1ps
// Shared types and constants for the running sample statistics block.
// No dependencies; every other module of the block imports this package.
package rss_pkg;

	// Port payload widths
	localparam int SDATA_W = 24;
	localparam int DATA_W  = 152;
	localparam int MUSER_W = 2;

	// Result field widths and their places in the master-side tdata
	localparam int CNT_W   = 16;
	localparam int SUM_W   = 40;
	localparam int AVG_W   = 24;
	localparam int VAR_W   = 47;
	localparam int DEV_W   = 24;
	localparam int OFS_SUM = CNT_W;
	localparam int OFS_AVG = OFS_SUM + SUM_W;
	localparam int OFS_VAR = OFS_AVG + AVG_W;
	localparam int OFS_DEV = OFS_VAR + VAR_W;
	localparam int FIELDS_W = OFS_DEV + DEV_W;

	// Accumulator and back-end datapath widths
	localparam int SQS_W   = 63;
	localparam int NUM_W   = 79;
	localparam int PROD_W  = NUM_W + 1;
	localparam int MPLR_W  = SUM_W;
	localparam int DVS_W   = 2 * CNT_W;
	localparam int REM_W   = DVS_W + 1;
	localparam int RAD_W   = 2 * DEV_W;
	localparam int SREM_W  = DEV_W + 2;
	localparam int SQRT_ITERS = RAD_W / 2;
	localparam int ITER_W  = $clog2(NUM_W);

	// Group-end queue
	localparam int QDEPTH  = 2;
	localparam int PTR_W   = $clog2(QDEPTH);

	// Input item kinds carried on tuser
	localparam logic KIND_SAMPLE = 1'b0;
	localparam logic KIND_END    = 1'b1;

	// Totals of one finished group, handed from front to back
	typedef struct packed {
		logic [CNT_W-1:0]        cnt;
		logic signed [SUM_W-1:0] sum;
		logic [SQS_W-1:0]        sqs;
		logic                    sat;
	} snap_t;

	// Back-end sequencer states
	typedef enum logic [2:0] {
		BK_IDLE,
		BK_SETUP,
		BK_MEAN,
		BK_MULA,
		BK_MULB,
		BK_DIV,
		BK_SQRT,
		BK_DONE
	} back_state_t;

endpackage

FILE: sv/running_sample_statistics.sv
`timescale 1ns / 1ps
// Running sample statistics over groups of signed fixed-point samples.
//
// Input stream: tuser is the item kind (sample or group end), tdata the
// signed sample. Samples are taken one per cycle unless a group end waits
// on a full queue; each is squared in a registered stage and added into the
// sum, sum of squares and count. A group end moves the group totals into a
// two-entry queue and clears the accumulators, so the next group starts right away.
// The back end takes one group at a time from the queue and produces one
// result: count, total, mean, sample variance, deviation, flags.
// It runs the mean division, two shift-add multiplies, the variance division
// and the square root in turn, bit-serially; an empty group skips them all,
// one sample stops after the mean, and a negative numerator skips the last two.
// When the receiver stalls, the result holds in the output register; the
// front keeps taking samples and stops only at a group end with the queue full.
// Reset clears the accumulators, the queue and the back-end sequencer.
// Depends on rss_pkg, rss_front, rss_queue and rss_back.
module running_sample_statistics #(
	parameter int SAMPLE_BITS = 24,
	parameter int COUNT_BITS  = 16
) (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        s_axis_tvalid,
	output logic                        s_axis_tready,
	input  logic [rss_pkg::SDATA_W-1:0] s_axis_tdata,   // sample
	input  logic                        s_axis_tuser,   // kind
	output logic                        m_axis_tvalid,
	input  logic                        m_axis_tready,
	// count, total, average, spread_squared, deviation, zero fill
	output logic [rss_pkg::DATA_W-1:0]  m_axis_tdata,
	// spread_valid, overflowed
	output logic [rss_pkg::MUSER_W-1:0] m_axis_tuser
);
	import rss_pkg::*;

	logic  q_full;
	logic  q_push;
	snap_t q_snap;
	logic  q_valid;
	snap_t q_head;
	logic  q_pop;

	rss_front #(
		.SAMPLE_BITS(SAMPLE_BITS),
		.COUNT_BITS (COUNT_BITS)
	) u_front (
		.clk          (clk),
		.arst_n       (arst_n),
		.s_axis_tvalid(s_axis_tvalid),
		.s_axis_tready(s_axis_tready),
		.s_axis_tdata (s_axis_tdata),
		.s_axis_tuser (s_axis_tuser),
		.q_full       (q_full),
		.q_push       (q_push),
		.q_snap       (q_snap)
	);

	rss_queue u_queue (
		.clk      (clk),
		.arst_n   (arst_n),
		.push     (q_push),
		.push_snap(q_snap),
		.full     (q_full),
		.valid    (q_valid),
		.head     (q_head),
		.pop      (q_pop)
	);

	rss_back u_back (
		.clk          (clk),
		.arst_n       (arst_n),
		.q_valid      (q_valid),
		.q_head       (q_head),
		.q_pop        (q_pop),
		.m_axis_tvalid(m_axis_tvalid),
		.m_axis_tready(m_axis_tready),
		.m_axis_tdata (m_axis_tdata),
		.m_axis_tuser (m_axis_tuser)
	);

	// A valid variance needs at least two samples
	assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid && m_axis_tuser[0] |-> m_axis_tdata[CNT_W-1:0] >= CNT_W'(2))
		else $error("spread_valid with fewer than two samples");

	// An empty group reports a zero total and mean
	assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid && (m_axis_tdata[CNT_W-1:0] == '0) |->
		(m_axis_tdata[OFS_SUM +: SUM_W] == '0) && (m_axis_tdata[OFS_AVG +: AVG_W] == '0))
		else $error("empty group with nonzero total or mean");

	// Fewer than two samples leave variance and deviation at zero
	assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid && (m_axis_tdata[CNT_W-1:0] < CNT_W'(2)) |->
		(m_axis_tdata[OFS_VAR +: VAR_W] == '0) && (m_axis_tdata[OFS_DEV +: DEV_W] == '0))
		else $error("variance reported for a group of fewer than two samples");

	// The front never pushes group totals into a full queue
	assert property (@(posedge clk) disable iff (!arst_n)
		q_push |-> !q_full)
		else $error("group totals pushed into a full queue");

endmodule

FILE: sv/rss_front.sv
`timescale 1ns / 1ps
// Input side: takes samples and group ends, squares each sample, keeps the
// running sum, sum of squares and count. Depends on rss_pkg.
module rss_front #(
	parameter int SAMPLE_BITS = 24,
	parameter int COUNT_BITS  = 16
) (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic                         s_axis_tvalid,
	output logic                         s_axis_tready,
	input  logic [rss_pkg::SDATA_W-1:0]  s_axis_tdata,   // sample
	input  logic                         s_axis_tuser,   // kind
	input  logic                         q_full,
	output logic                         q_push,
	output rss_pkg::snap_t               q_snap
);
	import rss_pkg::*;

	localparam int SQ_W = 2 * SAMPLE_BITS;

	logic signed [SAMPLE_BITS-1:0] smp_in;
	logic [SAMPLE_BITS-1:0]        mag_in;
	logic [SQ_W-1:0]               sq_in;
	logic                          accept;
	logic                          adv;

	logic                          vld_s1;
	logic                          kind_s1;
	logic signed [SAMPLE_BITS-1:0] smp_s1;
	logic [SQ_W-1:0]               sq_s1;

	logic signed [SUM_W-1:0]       sum_q;
	logic [SQS_W-1:0]              sqs_q;
	logic [COUNT_BITS-1:0]         cnt_q;
	logic                          sat_q;

	// Take the sample from the low bits and square its magnitude
	assign smp_in = s_axis_tdata[SAMPLE_BITS-1:0];
	assign mag_in = smp_in[SAMPLE_BITS-1] ? SAMPLE_BITS'(-smp_in) : SAMPLE_BITS'(smp_in);
	assign sq_in  = SQ_W'(mag_in) * SQ_W'(mag_in);

	// A group end waits in stage 1 while the queue is full
	assign adv           = vld_s1 && !(kind_s1 == KIND_END && q_full);
	assign s_axis_tready = !vld_s1 || adv;
	assign accept        = s_axis_tvalid && s_axis_tready;

	assign q_push = adv && (kind_s1 == KIND_END);
	assign q_snap = '{cnt: CNT_W'(cnt_q), sum: sum_q, sqs: sqs_q, sat: sat_q};

	// Stage 1 valid
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
		end else if (accept) begin
			vld_s1 <= 1'b1;
		end else if (adv) begin
			vld_s1 <= 1'b0;
		end
	end

	// Stage 1 payload
	always_ff @(posedge clk) begin
		if (accept) begin
			kind_s1 <= s_axis_tuser;
			smp_s1  <= smp_in;
			sq_s1   <= sq_in;
		end
	end

	// Accumulate samples, drop them once the count is full, clear on group end
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			sum_q <= '0;
			sqs_q <= '0;
			cnt_q <= '0;
			sat_q <= 1'b0;
		end else if (adv) begin
			if (kind_s1 == KIND_END) begin
				sum_q <= '0;
				sqs_q <= '0;
				cnt_q <= '0;
				sat_q <= 1'b0;
			end else if (cnt_q == '1) begin
				sat_q <= 1'b1;
			end else begin
				sum_q <= sum_q + SUM_W'(smp_s1);
				sqs_q <= sqs_q + SQS_W'(sq_s1);
				cnt_q <= cnt_q + COUNT_BITS'(1);
			end
		end
	end

endmodule

FILE: sv/rss_queue.sv
`timescale 1ns / 1ps
// Short register queue of group totals between front and back.
// Depends on rss_pkg.
module rss_queue (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           push,
	input  rss_pkg::snap_t push_snap,
	output logic           full,
	output logic           valid,
	output rss_pkg::snap_t head,
	input  logic           pop
);
	import rss_pkg::*;

	snap_t          ent_q [QDEPTH];
	logic [PTR_W-1:0] wr_q;
	logic [PTR_W-1:0] rd_q;
	logic [PTR_W:0]   fill_q;

	assign full  = (fill_q == (PTR_W+1)'(QDEPTH));
	assign valid = (fill_q != '0);
	assign head  = ent_q[rd_q];

	// Hold entries
	always_ff @(posedge clk) begin
		if (push) begin
			ent_q[wr_q] <= push_snap;
		end
	end

	// Advance pointers and fill level
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_q   <= '0;
			rd_q   <= '0;
			fill_q <= '0;
		end else begin
			if (push) begin
				wr_q <= wr_q + PTR_W'(1);
			end
			if (pop) begin
				rd_q <= rd_q + PTR_W'(1);
			end
			if (push && !pop) begin
				fill_q <= fill_q + (PTR_W+1)'(1);
			end else if (pop && !push) begin
				fill_q <= fill_q - (PTR_W+1)'(1);
			end
		end
	end

endmodule

FILE: sv/rss_back.sv
`timescale 1ns / 1ps
// Group-end arithmetic: mean, sample variance and square root worked out one
// bit or one digit per cycle, then held in the output register. Depends on rss_pkg.
module rss_back (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        q_valid,
	input  rss_pkg::snap_t              q_head,
	output logic                        q_pop,
	output logic                        m_axis_tvalid,
	input  logic                        m_axis_tready,
	// count, total, average, spread_squared, deviation, zero fill
	output logic [rss_pkg::DATA_W-1:0]  m_axis_tdata,
	// spread_valid, overflowed
	output logic [rss_pkg::MUSER_W-1:0] m_axis_tuser
);
	import rss_pkg::*;

	back_state_t state_q, state_d;
	logic [ITER_W-1:0] iter_q;
	logic              last_iter;

	logic [CNT_W-1:0]        n_q;
	logic signed [SUM_W-1:0] sum_q;
	logic [SQS_W-1:0]        sqs_q;
	logic                    sat_q;
	logic                    neg_q;
	logic [SUM_W-1:0]        mag_q;

	logic [DVS_W-1:0]        dvs_q;
	logic [NUM_W-1:0]        num_q;
	logic [REM_W-1:0]        rem_q;
	logic [VAR_W-1:0]        quo_q;
	logic                    qovf_q;

	logic signed [PROD_W-1:0] prod_q;
	logic [NUM_W-1:0]         mcand_q;
	logic [MPLR_W-1:0]        mplr_q;

	logic [RAD_W-1:0]  rad_q;
	logic [DEV_W-1:0]  root_q;
	logic [SREM_W-1:0] srem_q;

	logic [AVG_W-1:0] avg_q;
	logic [VAR_W-1:0] var_q;
	logic             valid_q;

	// Divider step
	logic [REM_W-1:0] rem_sh;
	logic [REM_W:0]   rem_diff;
	logic             take;
	logic [REM_W-1:0] rem_nx;
	logic [VAR_W-1:0] quo_nx;
	logic             qovf_nx;
	logic [VAR_W-1:0] var_nx;

	// Multiplier step
	logic                     sub;
	logic [PROD_W-1:0]        addend;
	logic signed [PROD_W-1:0] prod_sum;
	logic signed [PROD_W-1:0] prod_nx;

	// Square-root step
	logic [SREM_W-1:0] srem_sh;
	logic [SREM_W:0]   sq_diff;
	logic              sq_take;

	logic [SUM_W-1:0] sum_mag;
	logic [SUM_W-1:0] quo_mean;
	logic [SUM_W-1:0] avg_full;
	logic [CNT_W-1:0] nm1;
	logic [DVS_W-1:0] dvs_var;

	assign last_iter = (iter_q == '0);

	// Restoring division, one quotient bit per cycle
	assign rem_sh   = {rem_q[REM_W-2:0], num_q[NUM_W-1]};
	assign rem_diff = {1'b0, rem_sh} - {2'b00, dvs_q};
	assign take     = !rem_diff[REM_W];
	assign rem_nx   = take ? rem_diff[REM_W-1:0] : rem_sh;
	assign quo_nx   = {quo_q[VAR_W-2:0], take};
	assign qovf_nx  = qovf_q | (take && (iter_q >= ITER_W'(VAR_W)));
	assign var_nx   = qovf_nx ? '1 : quo_nx;

	// Shift-add multiply; the second product is subtracted
	assign sub      = (state_q == BK_MULB);
	assign addend   = sub ? ~{1'b0, mcand_q} : {1'b0, mcand_q};
	assign prod_sum = prod_q + $signed(addend) + $signed(PROD_W'(sub));
	assign prod_nx  = mplr_q[0] ? prod_sum : prod_q;

	// Square root, two radicand bits per cycle
	assign srem_sh = {srem_q[SREM_W-3:0], rad_q[RAD_W-1 -: 2]};
	assign sq_diff = {1'b0, srem_sh} - {1'b0, root_q, 2'b01};
	assign sq_take = !sq_diff[SREM_W];

	// Sign handling and divisor for the variance
	assign sum_mag  = sum_q[SUM_W-1] ? SUM_W'(-sum_q) : SUM_W'(sum_q);
	assign quo_mean = quo_nx[SUM_W-1:0];
	assign avg_full = neg_q ? (SUM_W'(0) - quo_mean) : quo_mean;
	assign nm1      = n_q - CNT_W'(1);
	assign dvs_var  = DVS_W'(n_q) * DVS_W'(nm1);

	// State register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= BK_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	// Next state, queue pop and output valid
	always_comb begin
		state_d       = state_q;
		q_pop         = 1'b0;
		m_axis_tvalid = 1'b0;
		case (state_q)
			BK_IDLE: begin
				if (q_valid) begin
					q_pop   = 1'b1;
					state_d = BK_SETUP;
				end
			end
			BK_SETUP: begin
				state_d = (n_q == '0) ? BK_DONE : BK_MEAN;
			end
			BK_MEAN: begin
				if (last_iter) begin
					state_d = (n_q < CNT_W'(2)) ? BK_DONE : BK_MULA;
				end
			end
			BK_MULA: begin
				if (last_iter) begin
					state_d = BK_MULB;
				end
			end
			BK_MULB: begin
				if (last_iter) begin
					state_d = prod_nx[PROD_W-1] ? BK_DONE : BK_DIV;
				end
			end
			BK_DIV: begin
				if (last_iter) begin
					state_d = BK_SQRT;
				end
			end
			BK_SQRT: begin
				if (last_iter) begin
					state_d = BK_DONE;
				end
			end
			BK_DONE: begin
				m_axis_tvalid = 1'b1;
				if (m_axis_tready) begin
					state_d = BK_IDLE;
				end
			end
			default: begin
				state_d = BK_IDLE;
			end
		endcase
	end

	// Iteration counter: load at the start of each phase, count down
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			iter_q <= '0;
		end else begin
			case (state_q)
				BK_SETUP: iter_q <= ITER_W'(SUM_W - 1);
				BK_MEAN:  iter_q <= last_iter ? ITER_W'(CNT_W - 1) : iter_q - ITER_W'(1);
				BK_MULA:  iter_q <= last_iter ? ITER_W'(SUM_W - 1) : iter_q - ITER_W'(1);
				BK_MULB:  iter_q <= last_iter ? ITER_W'(NUM_W - 1) : iter_q - ITER_W'(1);
				BK_DIV:   iter_q <= last_iter ? ITER_W'(SQRT_ITERS - 1) : iter_q - ITER_W'(1);
				BK_SQRT:  iter_q <= last_iter ? '0 : iter_q - ITER_W'(1);
				default:  iter_q <= '0;
			endcase
		end
	end

	// Datapath
	always_ff @(posedge clk) begin
		case (state_q)
			BK_IDLE: begin
				if (q_valid) begin
					n_q   <= q_head.cnt;
					sum_q <= q_head.sum;
					sqs_q <= q_head.sqs;
					sat_q <= q_head.sat;
				end
			end
			BK_SETUP: begin
				mag_q   <= sum_mag;
				neg_q   <= sum_q[SUM_W-1];
				num_q   <= {sum_mag, (NUM_W - SUM_W)'(0)};
				rem_q   <= '0;
				quo_q   <= '0;
				dvs_q   <= DVS_W'(n_q);
				avg_q   <= '0;
				var_q   <= '0;
				root_q  <= '0;
				valid_q <= 1'b0;
			end
			BK_MEAN: begin
				num_q <= num_q << 1;
				rem_q <= rem_nx;
				quo_q <= quo_nx;
				if (last_iter) begin
					avg_q   <= avg_full[AVG_W-1:0];
					dvs_q   <= dvs_var;
					prod_q  <= '0;
					mcand_q <= NUM_W'(sqs_q);
					mplr_q  <= MPLR_W'(n_q);
				end
			end
			BK_MULA: begin
				prod_q <= prod_nx;
				if (last_iter) begin
					mcand_q <= NUM_W'(mag_q);
					mplr_q  <= mag_q;
				end else begin
					mcand_q <= mcand_q << 1;
					mplr_q  <= mplr_q >> 1;
				end
			end
			BK_MULB: begin
				prod_q  <= prod_nx;
				mcand_q <= mcand_q << 1;
				mplr_q  <= mplr_q >> 1;
				if (last_iter) begin
					valid_q <= 1'b1;
					num_q   <= prod_nx[NUM_W-1:0];
					rem_q   <= '0;
					quo_q   <= '0;
					qovf_q  <= 1'b0;
				end
			end
			BK_DIV: begin
				num_q  <= num_q << 1;
				rem_q  <= rem_nx;
				quo_q  <= quo_nx;
				qovf_q <= qovf_nx;
				if (last_iter) begin
					var_q  <= var_nx;
					rad_q  <= {1'b0, var_nx};
					srem_q <= '0;
					root_q <= '0;
				end
			end
			BK_SQRT: begin
				rad_q  <= rad_q << 2;
				srem_q <= sq_take ? sq_diff[SREM_W-1:0] : srem_sh;
				root_q <= {root_q[DEV_W-2:0], sq_take};
			end
			default: begin
			end
		endcase
	end

	assign m_axis_tdata = {{(DATA_W - FIELDS_W){1'b0}}, root_q, var_q, avg_q, sum_q, n_q};
	assign m_axis_tuser = {sat_q, valid_q};

endmodule
